>>> design/aasd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aasd_pkg
// Types, sizes and model tables for the adaptive arithmetic symbol decoder.
// ----------------------------------------------------------------------------
package aasd_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int CODE_BITS   = 26;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int MODEL_COUNT = 9;
  localparam int TABLE_SIZE  = 267;
  localparam int ADDR_W      = 9;
  localparam int FREQ_W      = 11;
  localparam int LIMIT_BIG   = 1024;
  localparam int LIMIT_SMALL = 256;

  localparam logic [2:0] REQ_LOAD   = 3'd0;
  localparam logic [2:0] REQ_START  = 3'd1;
  localparam logic [2:0] REQ_SYMBOL = 3'd2;
  localparam logic [2:0] REQ_BITS   = 3'd3;
  localparam logic [2:0] REQ_RESET  = 3'd4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic [3:0] model_select;
    logic [5:0] bit_count;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        store_overflow;
    logic        store_underflow;
  } rsp_t;

  function automatic logic [ADDR_W-1:0] m_base(input logic [3:0] m);
    case (m)
      4'd0: m_base = 9'd0;
      4'd1: m_base = 9'd2;
      4'd2: m_base = 9'd13;
      4'd3: m_base = 9'd15;
      4'd4: m_base = 9'd19;
      4'd5: m_base = 9'd27;
      4'd6: m_base = 9'd43;
      4'd7: m_base = 9'd75;
      default: m_base = 9'd139;
    endcase
  endfunction

  function automatic logic [7:0] m_size(input logic [3:0] m);
    case (m)
      4'd0: m_size = 8'd2;
      4'd1: m_size = 8'd11;
      4'd2: m_size = 8'd2;
      4'd3: m_size = 8'd4;
      4'd4: m_size = 8'd8;
      4'd5: m_size = 8'd16;
      4'd6: m_size = 8'd32;
      4'd7: m_size = 8'd64;
      default: m_size = 8'd128;
    endcase
  endfunction

  function automatic logic [7:0] m_first(input logic [3:0] m);
    m_first = (m == 4'd1) ? 8'd0 : m_size(m);
    if (m == 4'd0) m_first = 8'd0;
  endfunction

  function automatic logic [3:0] m_inc(input logic [3:0] m);
    case (m)
      4'd0: m_inc = 4'd1;
      4'd1, 4'd2: m_inc = 4'd8;
      4'd3, 4'd4, 4'd5: m_inc = 4'd4;
      4'd6, 4'd7: m_inc = 4'd2;
      default: m_inc = 4'd1;
    endcase
  endfunction

  function automatic logic [FREQ_W-1:0] m_limit(input logic [3:0] m);
    m_limit = (m == 4'd0) ? FREQ_W'(LIMIT_SMALL) : FREQ_W'(LIMIT_BIG);
  endfunction

  function automatic logic [3:0] inc_of_index(input logic [ADDR_W-1:0] idx);
    if (idx < 9'd2) inc_of_index = 4'd1;
    else if (idx < 9'd15) inc_of_index = 4'd8;
    else if (idx < 9'd43) inc_of_index = 4'd4;
    else if (idx < 9'd139) inc_of_index = 4'd2;
    else inc_of_index = 4'd1;
  endfunction

endpackage

>>> design/adaptive_arith_symbol_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_arith_symbol_decoder_unit
// Adaptive arithmetic decoder, nine frequency models in one table memory.
// ----------------------------------------------------------------------------
// channel  | ports                 | handshake
// request  | start, busy, req      | taken when start & !busy
// result   | done, rsp             | one cycle, done high, no stall
//
// Load and ignored requests go straight to S_FINISH. Start: S_CLEAR sweeps all 267
// entries, then S_FILL shifts in 26 code bits. Reset models: S_CLEAR from
// model 1 on. Symbol: two divides, S_SRD and S_SCMP per searched entry, S_NORM
// shifting one bit per cycle, S_HRD and S_HWR per entry when the model halves.
// The freq table memory has one registered read port; it sets the search pace.
// Reset is synchronous and starts a whole-table sweep with busy high.
module adaptive_arith_symbol_decoder_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  aasd_pkg::req_t  req,
  output logic            done,
  output aasd_pkg::rsp_t  rsp
);
  import aasd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FILL, S_DIV1, S_DIV2, S_SRD, S_SCMP, S_MUL, S_UPD,
    S_NORM, S_HRD, S_HWR, S_SYM, S_FINISH
  } state_t;

  state_t state;

  logic [7:0]  byte_store [STORE_DEPTH];
  logic [PTR_W-1:0] store_read_ptr, store_write_ptr;
  logic [CNT_W-1:0] store_count;
  logic [7:0]  bit_shift;
  logic [3:0]  bits_remaining;
  logic [CODE_BITS-1:0] coder_range, coder_code;
  logic [FREQ_W-1:0] total_freq [MODEL_COUNT];
  logic [FREQ_W-1:0] freq_mem [TABLE_SIZE];
  logic [FREQ_W-1:0] rd_data;
  logic        underflow_seen;

  logic [2:0]  cur_req;
  logic [3:0]  msel;
  logic [5:0]  bits_total, bit_idx;
  logic [31:0] value;
  logic [ADDR_W-1:0] clr_idx;
  logic [4:0]  fill_cnt;

  // shared restoring divider
  logic [CODE_BITS-1:0] div_dvd, div_dvs, div_quo;
  logic [CODE_BITS:0]   div_rem;
  logic [4:0]  div_cnt;
  logic [CODE_BITS-1:0] scale, target;

  logic [6:0]  n, h;
  logic [FREQ_W:0] cum;
  logic [FREQ_W-1:0] sz, htot;
  logic [CODE_BITS+FREQ_W-1:0] low, szs;
  logic [7:0]  sym;

  // combinational helpers
  logic [ADDR_W-1:0] base, rd_addr;
  logic [7:0]  cnt;
  logic [3:0]  inc;
  logic [FREQ_W-1:0] tot;
  logic        need_fetch, nbit;
  logic [7:0]  fetch_byte;
  logic [3:0]  rem_next;
  logic [CODE_BITS:0] div_sh;
  logic [FREQ_W:0] cum_f;
  logic [CODE_BITS-1:0] range_upd;

  assign base = m_base(msel);
  assign cnt  = m_size(msel);
  assign inc  = m_inc(msel);
  assign tot  = total_freq[msel];
  assign rd_addr = (state == S_HRD) ? base + ADDR_W'(h) : base + ADDR_W'(n);

  assign need_fetch = (bits_remaining == 4'd0);
  assign fetch_byte = need_fetch ? ((store_count != '0) ? byte_store[store_read_ptr] : 8'd0)
                                 : bit_shift;
  assign rem_next   = (need_fetch ? 4'd8 : bits_remaining) - 4'd1;
  assign nbit       = fetch_byte[rem_next[2:0]];

  assign div_sh = {div_rem[CODE_BITS-1:0], div_dvd[CODE_BITS-1]};
  assign cum_f  = cum + {1'b0, rd_data};

  always_comb begin
    if (cum + {1'b0, sz} == {1'b0, tot})
      range_upd = coder_range - low[CODE_BITS-1:0];
    else
      range_upd = szs[CODE_BITS-1:0];
    if (range_upd == '0) range_upd = CODE_BITS'(1);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    rd_data <= freq_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // table sweep after reset, back to idle without a result
      state <= S_CLEAR;
      clr_idx <= '0;
      cur_req <= REQ_LOAD;
      store_read_ptr <= '0;
      store_write_ptr <= '0;
      store_count <= '0;
      bit_shift <= '0;
      bits_remaining <= '0;
      coder_range <= CODE_BITS'(1) << (CODE_BITS - 1);
      coder_code <= '0;
      for (int m = 0; m < MODEL_COUNT; m++)
        total_freq[m] <= FREQ_W'(m_inc(4'(m)) * m_size(4'(m)));
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_req <= req.req_type;
            msel <= req.model_select;
            bits_total <= (req.bit_count > 6'd32) ? 6'd32 : req.bit_count;
            bit_idx <= '0;
            value <= '0;
            underflow_seen <= 1'b0;
            rsp.store_overflow <= (req.req_type == REQ_LOAD) &&
                                  (store_count >= CNT_W'(STORE_DEPTH));
            case (req.req_type)
              REQ_LOAD: begin
                if (store_count < CNT_W'(STORE_DEPTH)) begin
                  byte_store[store_write_ptr] <= req.data_byte;
                  store_write_ptr <= (store_write_ptr == PTR_W'(STORE_DEPTH - 1)) ? '0
                                     : store_write_ptr + PTR_W'(1);
                  store_count <= store_count + CNT_W'(1);
                end
                state <= S_FINISH;
              end
              REQ_START: begin
                clr_idx <= '0;
                bit_shift <= '0;
                bits_remaining <= '0;
                coder_range <= CODE_BITS'(1) << (CODE_BITS - 1);
                coder_code <= '0;
                fill_cnt <= 5'(CODE_BITS);
                for (int m = 0; m < MODEL_COUNT; m++)
                  total_freq[m] <= FREQ_W'(m_inc(4'(m)) * m_size(4'(m)));
                state <= S_CLEAR;
              end
              REQ_RESET: begin
                clr_idx <= m_base(4'd1);
                for (int m = 1; m < MODEL_COUNT; m++)
                  total_freq[m] <= FREQ_W'(m_inc(4'(m)) * m_size(4'(m)));
                state <= S_CLEAR;
              end
              REQ_SYMBOL, REQ_BITS: begin
                if (req.model_select < 4'(MODEL_COUNT) &&
                    !(req.req_type == REQ_BITS && req.bit_count == 6'd0)) begin
                  div_dvd <= coder_range;
                  div_dvs <= CODE_BITS'(total_freq[req.model_select]);
                  div_rem <= '0;
                  div_cnt <= '0;
                  state <= S_DIV1;
                end else begin
                  state <= S_FINISH;
                end
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_CLEAR: begin
          freq_mem[clr_idx] <= FREQ_W'(inc_of_index(clr_idx));
          clr_idx <= clr_idx + ADDR_W'(1);
          if (clr_idx == ADDR_W'(TABLE_SIZE - 1)) begin
            if (cur_req == REQ_START) state <= S_FILL;
            else if (cur_req == REQ_RESET) state <= S_FINISH;
            else state <= S_IDLE;
          end
        end
        S_FILL: begin
          bit_shift <= fetch_byte;
          bits_remaining <= rem_next;
          if (need_fetch) begin
            if (store_count != '0) begin
              store_read_ptr <= (store_read_ptr == PTR_W'(STORE_DEPTH - 1)) ? '0
                                : store_read_ptr + PTR_W'(1);
              store_count <= store_count - CNT_W'(1);
            end else begin
              underflow_seen <= 1'b1;
            end
          end
          coder_code <= {coder_code[CODE_BITS-2:0], nbit};
          fill_cnt <= fill_cnt - 5'd1;
          if (fill_cnt == 5'd1) state <= S_FINISH;
        end
        S_DIV1, S_DIV2: begin
          if (div_cnt == 5'(CODE_BITS)) begin
            // quotient complete
            div_cnt <= '0;
            if (state == S_DIV1) begin
              scale <= (div_quo == '0) ? CODE_BITS'(1) : div_quo;
              div_dvd <= coder_code;
              div_dvs <= (div_quo == '0) ? CODE_BITS'(1) : div_quo;
              div_rem <= '0;
              state <= S_DIV2;
            end else begin
              target <= div_quo;
              n <= '0;
              cum <= '0;
              state <= S_SRD;
            end
          end else begin
            div_dvd <= {div_dvd[CODE_BITS-2:0], 1'b0};
            if (div_sh >= {1'b0, div_dvs}) begin
              div_rem <= div_sh - {1'b0, div_dvs};
              div_quo <= {div_quo[CODE_BITS-2:0], 1'b1};
            end else begin
              div_rem <= div_sh;
              div_quo <= {div_quo[CODE_BITS-2:0], 1'b0};
            end
            div_cnt <= div_cnt + 5'd1;
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if ((8'(n) + 8'd1 < cnt) && !(CODE_BITS'(cum_f) > target)) begin
            cum <= cum_f;
            n <= n + 7'd1;
            state <= S_SRD;
          end else begin
            sz <= rd_data;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          low <= (CODE_BITS + FREQ_W)'(scale) * (CODE_BITS + FREQ_W)'(cum);
          szs <= (CODE_BITS + FREQ_W)'(scale) * (CODE_BITS + FREQ_W)'(sz);
          state <= S_UPD;
        end
        S_UPD: begin
          coder_code <= coder_code - low[CODE_BITS-1:0];
          coder_range <= range_upd;
          freq_mem[rd_addr] <= sz + FREQ_W'(inc);
          total_freq[msel] <= tot + FREQ_W'(inc);
          sym <= m_first(msel) + 8'(n);
          state <= S_NORM;
        end
        S_NORM: begin
          if (coder_range <= (CODE_BITS'(1) << (CODE_BITS - 2))) begin
            coder_range <= {coder_range[CODE_BITS-2:0], 1'b0};
            coder_code <= {coder_code[CODE_BITS-2:0], nbit};
            bit_shift <= fetch_byte;
            bits_remaining <= rem_next;
            if (need_fetch) begin
              if (store_count != '0) begin
                store_read_ptr <= (store_read_ptr == PTR_W'(STORE_DEPTH - 1)) ? '0
                                  : store_read_ptr + PTR_W'(1);
                store_count <= store_count - CNT_W'(1);
              end else begin
                underflow_seen <= 1'b1;
              end
            end
          end else if (tot > m_limit(msel)) begin
            h <= '0;
            htot <= '0;
            state <= S_HRD;
          end else begin
            state <= S_SYM;
          end
        end
        S_HRD: state <= S_HWR;
        S_HWR: begin
          freq_mem[base + ADDR_W'(h)] <= FREQ_W'(({1'b0, rd_data} + 12'd1) >> 1);
          htot <= htot + FREQ_W'(({1'b0, rd_data} + 12'd1) >> 1);
          h <= h + 7'd1;
          if (8'(h) + 8'd1 == cnt) begin
            total_freq[msel] <= htot + FREQ_W'(({1'b0, rd_data} + 12'd1) >> 1);
            state <= S_SYM;
          end else begin
            state <= S_HRD;
          end
        end
        S_SYM: begin
          if (cur_req == REQ_BITS) begin
            if (sym != 8'd0) value[bit_idx[4:0]] <= 1'b1;
            bit_idx <= bit_idx + 6'd1;
            if (bit_idx + 6'd1 == bits_total) begin
              state <= S_FINISH;
            end else begin
              div_dvd <= coder_range;
              div_dvs <= CODE_BITS'(tot);
              div_rem <= '0;
              div_cnt <= '0;
              state <= S_DIV1;
            end
          end else begin
            value <= {24'd0, sym};
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          rsp.value <= value;
          rsp.store_underflow <= underflow_seen;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
